[rtl/bir_pkg.sv]
// Package for the bilinear image rotation unit.
// Holds the store geometry, fixed-point sizes and the structs passed between pipeline stages.
// No dependencies.
package bir_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int HALF_W    = SIDE_W - 1;
  localparam int BANK_AW   = 2 * HALF_W;
  localparam int PIX_W     = 8;
  localparam int FRAC_W    = 15;
  localparam int WIDTH_W   = 9;
  localparam int ANGLE_W   = 16;
  localparam int POS_W     = 28;
  localparam int FLOOR_W   = POS_W - FRAC_W;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_SIN   = 2'd1;
  localparam logic [1:0] REG_COS   = 2'd2;

  localparam logic KIND_LOAD = 1'b0;

  // Output of the coordinate mapping stages.
  typedef struct packed {
    logic                 valid;
    logic                 req;
    logic [SIDE_W-1:0]    px;
    logic [SIDE_W-1:0]    py;
    logic [PIX_W-1:0]     value;
    logic [SIDE_W-1:0]    fx;
    logic [SIDE_W-1:0]    fy;
    logic [FRAC_W-1:0]    frac_x;
    logic [FRAC_W-1:0]    frac_y;
    logic                 outside;
  } bir_map_t;

  // Output of the image store stage, requests only.
  typedef struct packed {
    logic                 valid;
    logic [SIDE_W-1:0]    px;
    logic [SIDE_W-1:0]    py;
    logic [FRAC_W-1:0]    frac_x;
    logic [FRAC_W-1:0]    frac_y;
    logic                 outside;
    logic [PIX_W-1:0]     p00;
    logic [PIX_W-1:0]     p10;
    logic [PIX_W-1:0]     p01;
    logic [PIX_W-1:0]     p11;
  } bir_pix_t;

endpackage

[rtl/bir_map.sv]
// Coordinate mapping: three register stages from destination pixel to source floor and fraction.
// Depends on bir_pkg.
module bir_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_fire,
  input  logic                          kind,
  input  logic [bir_pkg::SIDE_W-1:0]    pix_x,
  input  logic [bir_pkg::SIDE_W-1:0]    pix_y,
  input  logic [bir_pkg::PIX_W-1:0]     pix_value,
  input  logic [bir_pkg::WIDTH_W-1:0]   width_eff,
  input  logic signed [bir_pkg::ANGLE_W-1:0] sin_a,
  input  logic signed [bir_pkg::ANGLE_W-1:0] cos_a,
  output bir_pkg::bir_map_t             map_out
);
  import bir_pkg::*;

  localparam int PROD_W = SIDE_W + 1 + ANGLE_W;
  localparam int WPROD_W = WIDTH_W + 1 + ANGLE_W + 1;

  // Stage 1: products.
  logic                      v1, req1;
  logic [SIDE_W-1:0]         px1, py1;
  logic [PIX_W-1:0]          val1;
  logic signed [PROD_W-1:0]  xc1, ys1, xs1, yc1;
  logic signed [WPROD_W-1:0] wcs1, wcd1;
  // Stage 2: source point in Q.15.
  logic                      v2, req2;
  logic [SIDE_W-1:0]         px2, py2;
  logic [PIX_W-1:0]          val2;
  logic signed [POS_W-1:0]   x15, y15;

  logic signed [SIDE_W:0]    sx, sy;
  logic signed [ANGLE_W:0]   c_plus_s, c_minus_s;
  logic signed [WIDTH_W:0]   w_s;
  logic signed [POS_W-1:0]   wb, x15_next, y15_next;
  logic signed [FLOOR_W-1:0] fx, fy;
  logic signed [FLOOR_W:0]   hx, hy, w_cmp;
  logic                      out_next;

  assign sx        = $signed({1'b0, pix_x});
  assign sy        = $signed({1'b0, pix_y});
  assign w_s       = $signed({1'b0, width_eff});
  assign c_plus_s  = (ANGLE_W+1)'(cos_a) + (ANGLE_W+1)'(sin_a);
  assign c_minus_s = (ANGLE_W+1)'(cos_a) - (ANGLE_W+1)'(sin_a);

  always_ff @(posedge clk) begin
    if (en) begin
      px1  <= pix_x;
      py1  <= pix_y;
      val1 <= pix_value;
      req1 <= kind;
      xc1  <= sx * cos_a;
      ys1  <= sy * sin_a;
      xs1  <= sx * sin_a;
      yc1  <= sy * cos_a;
      wcs1 <= w_s * c_plus_s;
      wcd1 <= w_s * c_minus_s;
    end
  end

  assign wb = POS_W'(w_s) <<< FRAC_W - 1;
  assign x15_next = wb - POS_W'(wcs1) + (POS_W'(xc1) <<< 1) + (POS_W'(ys1) <<< 1);
  assign y15_next = wb - POS_W'(wcd1) - (POS_W'(xs1) <<< 1) + (POS_W'(yc1) <<< 1);

  always_ff @(posedge clk) begin
    if (en) begin
      px2  <= px1;
      py2  <= py1;
      val2 <= val1;
      req2 <= req1;
      x15  <= x15_next;
      y15  <= y15_next;
    end
  end

  // Floor is an arithmetic shift; the ceiling only steps up when a fraction remains.
  assign fx    = x15[POS_W-1:FRAC_W];
  assign fy    = y15[POS_W-1:FRAC_W];
  assign hx    = (FLOOR_W+1)'(fx) + (FLOOR_W+1)'(|x15[FRAC_W-1:0]);
  assign hy    = (FLOOR_W+1)'(fy) + (FLOOR_W+1)'(|y15[FRAC_W-1:0]);
  assign w_cmp = (FLOOR_W+1)'(w_s);
  assign out_next = fx[FLOOR_W-1] | fy[FLOOR_W-1] | (hx >= w_cmp) | (hy >= w_cmp);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      map_out.valid <= 1'b0;
    end else if (en) begin
      v1            <= in_fire;
      v2            <= v1;
      map_out.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      map_out.req     <= req2;
      map_out.px      <= px2;
      map_out.py      <= py2;
      map_out.value   <= val2;
      map_out.fx      <= fx[SIDE_W-1:0];
      map_out.fy      <= fy[SIDE_W-1:0];
      map_out.frac_x  <= x15[FRAC_W-1:0];
      map_out.frac_y  <= y15[FRAC_W-1:0];
      map_out.outside <= out_next;
    end
  end

endmodule

[rtl/bir_store.sv]
// Source image store in four banks split by column and row parity, so the four
// neighbours of a point come from a single read of all banks. Depends on bir_pkg.
module bir_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  bir_pkg::bir_map_t  map_in,
  output bir_pkg::bir_pix_t  pix_out
);
  import bir_pkg::*;

  logic [PIX_W-1:0]   rd [4];
  logic [HALF_W-1:0]  col_even, col_odd, row_even, row_odd;
  logic [SIDE_W:0]    fx_up, fy_up;
  logic [1:0]         wr_bank;
  logic [BANK_AW-1:0] wr_addr;
  logic               wr_en;
  logic               par_x, par_y;

  // An even bank holds the neighbour at floor or floor+1, whichever is even.
  assign fx_up    = (SIDE_W+1)'(map_in.fx) + 1'b1;
  assign fy_up    = (SIDE_W+1)'(map_in.fy) + 1'b1;
  assign col_even = fx_up[SIDE_W-1:1];
  assign col_odd  = map_in.fx[SIDE_W-1:1];
  assign row_even = fy_up[SIDE_W-1:1];
  assign row_odd  = map_in.fy[SIDE_W-1:1];

  assign wr_en   = en & map_in.valid & (map_in.req == KIND_LOAD);
  assign wr_bank = {map_in.py[0], map_in.px[0]};
  assign wr_addr = {map_in.py[SIDE_W-1:1], map_in.px[SIDE_W-1:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0]   mem [2**BANK_AW];
    logic [BANK_AW-1:0] rd_addr;
    assign rd_addr = {(b / 2 == 1) ? row_odd : row_even, (b % 2 == 1) ? col_odd : col_even};
    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 2'(b)) begin
        mem[wr_addr] <= map_in.value;
      end
      if (en) begin
        rd[b] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (en) begin
      pix_out.valid <= map_in.valid & (map_in.req != KIND_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out.px      <= map_in.px;
      pix_out.py      <= map_in.py;
      pix_out.frac_x  <= map_in.frac_x;
      pix_out.frac_y  <= map_in.frac_y;
      pix_out.outside <= map_in.outside;
      par_x           <= map_in.fx[0];
      par_y           <= map_in.fy[0];
    end
  end

  assign pix_out.p00 = rd[{par_y, par_x}];
  assign pix_out.p10 = rd[{par_y, ~par_x}];
  assign pix_out.p01 = rd[{~par_y, par_x}];
  assign pix_out.p11 = rd[{~par_y, ~par_x}];

endmodule

[rtl/bir_blend.sv]
// Bilinear blend: horizontal row blends in one stage, vertical blend into the output register.
// Depends on bir_pkg.
module bir_blend (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  bir_pkg::bir_pix_t          pix_in,
  output logic                       out_valid,
  output logic [bir_pkg::PIX_W-1:0]  out_value,
  output logic [bir_pkg::SIDE_W-1:0] out_x,
  output logic [bir_pkg::SIDE_W-1:0] out_y,
  output logic                       outside
);
  import bir_pkg::*;

  localparam int WGT_W = FRAC_W + 1;
  localparam int ACC_W = PIX_W + WGT_W;

  logic                v5, out5;
  logic [SIDE_W-1:0]   px5, py5;
  logic [FRAC_W-1:0]   fy5;
  logic [PIX_W-1:0]    bot, top;
  logic [WGT_W-1:0]    wx0, wx1, wy0, wy1;
  logic [ACC_W-1:0]    bot_acc, top_acc, vert_acc;

  assign wx1 = WGT_W'(pix_in.frac_x);
  assign wx0 = WGT_W'(1 << FRAC_W) - wx1;
  assign bot_acc = ACC_W'(pix_in.p00) * ACC_W'(wx0) + ACC_W'(pix_in.p10) * ACC_W'(wx1);
  assign top_acc = ACC_W'(pix_in.p01) * ACC_W'(wx0) + ACC_W'(pix_in.p11) * ACC_W'(wx1);

  always_ff @(posedge clk) begin
    if (en) begin
      px5  <= pix_in.px;
      py5  <= pix_in.py;
      fy5  <= pix_in.frac_y;
      out5 <= pix_in.outside;
      bot  <= bot_acc[FRAC_W +: PIX_W];
      top  <= top_acc[FRAC_W +: PIX_W];
    end
  end

  assign wy1 = WGT_W'(fy5);
  assign wy0 = WGT_W'(1 << FRAC_W) - wy1;
  assign vert_acc = ACC_W'(bot) * ACC_W'(wy0) + ACC_W'(top) * ACC_W'(wy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= pix_in.valid;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x     <= px5;
      out_y     <= py5;
      outside   <= out5;
      out_value <= out5 ? '0 : vert_acc[FRAC_W +: PIX_W];
    end
  end

endmodule

[rtl/bilinear_image_rotation_unit.sv]
// Bilinear image rotation unit, top level.
// Holds the configuration registers and links the mapping, store and blend stages.
// Depends on bir_pkg, bir_map, bir_store, bir_blend.
//
// Input channel (in_valid/in_ready): kind 0 loads pix_value into the image store at
// (pix_x, pix_y); kind 1 requests the rotated pixel at destination (pix_x, pix_y).
// Every request gives exactly one transfer on the output channel (out_valid/out_ready),
// in request order; loads give none.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 image width,
// 1 sine, 2 cosine, both Q1.14. cfg_ready is always high; write only while idle.
// Throughput is one item per cycle while the receiver does not stall: the pipeline is
// three mapping stages, the banked store read and two blend stages, and the four parity
// banks deliver all neighbours of a point in a single read.
// When the receiver stalls, the whole pipeline holds and in_ready drops; nothing is lost.
// Reset clears the pipeline valid bits and restores width 256, sine 0 and cosine 1.0.
// The image store is not cleared: pixels must be loaded before they are read.
module bilinear_image_rotation_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic [bir_pkg::SIDE_W-1:0] pix_x,
  input  logic [bir_pkg::SIDE_W-1:0] pix_y,
  input  logic [bir_pkg::PIX_W-1:0]  pix_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bir_pkg::PIX_W-1:0]  out_value,
  output logic [bir_pkg::SIDE_W-1:0] out_x,
  output logic [bir_pkg::SIDE_W-1:0] out_y,
  output logic                       outside,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [bir_pkg::ANGLE_W-1:0] cfg_data
);
  import bir_pkg::*;

  logic [WIDTH_W-1:0]        image_width, width_eff;
  logic signed [ANGLE_W-1:0] sin_angle, cos_angle;
  logic                      en;
  bir_map_t                  map_q;
  bir_pix_t                  pix_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_W'(MAX_SIDE);
      sin_angle   <= '0;
      cos_angle   <= ANGLE_W'(1 << (FRAC_W - 1));
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH: image_width <= cfg_data[WIDTH_W-1:0];
        REG_SIN:   sin_angle   <= cfg_data;
        REG_COS:   cos_angle   <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign width_eff = (image_width > WIDTH_W'(MAX_SIDE)) ? WIDTH_W'(MAX_SIDE) : image_width;

  // The pipeline advances whenever the output register is free or being emptied.
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  bir_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_fire   (in_valid),
    .kind      (kind),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_value (pix_value),
    .width_eff (width_eff),
    .sin_a     (sin_angle),
    .cos_a     (cos_angle),
    .map_out   (map_q)
  );

  bir_store u_store (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .map_in  (map_q),
    .pix_out (pix_q)
  );

  bir_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .pix_in    (pix_q),
    .out_valid (out_valid),
    .out_value (out_value),
    .out_x     (out_x),
    .out_y     (out_y),
    .outside   (outside)
  );

endmodule

[rtl/bir_checker.sv]
// Port-level checks for the bilinear image rotation unit, attached by bind.
// Depends on bir_pkg and bilinear_image_rotation_unit.
module bir_props (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_ready,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [bir_pkg::PIX_W-1:0]  out_value,
  input  logic [bir_pkg::SIDE_W-1:0] out_x,
  input  logic [bir_pkg::SIDE_W-1:0] out_y,
  input  logic                       outside
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_x)
      && $stable(out_y) && $stable(outside))
    else $error("output changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outside |-> out_value == '0)
    else $error("outside result not zero");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bilinear_image_rotation_unit bir_props u_bir_props (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_value (out_value),
  .out_x     (out_x),
  .out_y     (out_y),
  .outside   (outside)
);

[dv/bir_checker.sv]
// Checker for the bilinear image rotation unit: watches the input, output and
// configuration channels, predicts every rotated pixel and compares it with the block.
// Depends on bir_pkg.
module bir_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        kind,
  input  logic [bir_pkg::SIDE_W-1:0]  pix_x,
  input  logic [bir_pkg::SIDE_W-1:0]  pix_y,
  input  logic [bir_pkg::PIX_W-1:0]   pix_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [bir_pkg::PIX_W-1:0]   out_value,
  input  logic [bir_pkg::SIDE_W-1:0]  out_x,
  input  logic [bir_pkg::SIDE_W-1:0]  out_y,
  input  logic                        outside,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [bir_pkg::ANGLE_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending
);
  import bir_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]  value;
    logic [SIDE_W-1:0] x;
    logic [SIDE_W-1:0] y;
    logic              outside;
  } rot_pixel_t;

  logic [PIX_W-1:0] image_copy [0:MAX_SIDE*MAX_SIDE-1];
  logic [WIDTH_W-1:0] width_q;
  logic signed [ANGLE_W-1:0] sin_q;
  logic signed [ANGLE_W-1:0] cos_q;
  rot_pixel_t rotated_q[$];
  int mismatches;

  initial begin
    for (int i = 0; i < MAX_SIDE*MAX_SIDE; i++) image_copy[i] = '0;
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  function automatic longint pixel_of(longint px, longint py);
    return longint'(image_copy[py*MAX_SIDE + px]);
  endfunction

  function automatic longint mix(longint a, longint b, longint f);
    return (a * (65536 - f) + b * f) >>> 16;
  endfunction

  function automatic rot_pixel_t rotate_pixel(logic [SIDE_W-1:0] dx, logic [SIDE_W-1:0] dy);
    rot_pixel_t r;
    longint w, s, c, x15, y15, cx, cy, fx, fy, hx, hy, rx, ry, bot, upper;
    w = (width_q > MAX_SIDE) ? MAX_SIDE : longint'(width_q);
    s = longint'(sin_q);
    c = longint'(cos_q);
    x15 = w*16384 - w*(c + s) + 2*longint'(dx)*c + 2*longint'(dy)*s;
    y15 = w*16384 - w*(c - s) - 2*longint'(dx)*s + 2*longint'(dy)*c;
    // Q.15 to Q.16 is a plain doubling; the arithmetic shift then floors.
    cx = x15 * 2;
    cy = y15 * 2;
    fx = cx >>> 16;
    fy = cy >>> 16;
    rx = cx & 64'hFFFF;
    ry = cy & 64'hFFFF;
    hx = fx + ((rx != 0) ? 1 : 0);
    hy = fy + ((ry != 0) ? 1 : 0);
    r.x = dx;
    r.y = dy;
    if (fx < 0 || fy < 0 || hx >= w || hy >= w) begin
      r.value   = '0;
      r.outside = 1'b1;
    end else begin
      bot   = mix(pixel_of(fx, fy), pixel_of(hx, fy), rx);
      upper = mix(pixel_of(fx, hy), pixel_of(hx, hy), rx);
      r.value   = mix(bot, upper, ry) & 8'hFF;
      r.outside = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rot_pixel_t got;
    rot_pixel_t want;
    if (rst) begin
      width_q <= 9'd256;
      sin_q   <= 16'sd0;
      cos_q   <= 16'sd16384;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
          REG_SIN:   sin_q   <= cfg_data;
          REG_COS:   cos_q   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (kind == KIND_LOAD) image_copy[int'(pix_y)*MAX_SIDE + int'(pix_x)] = pix_value;
        else rotated_q.push_back(rotate_pixel(pix_x, pix_y));
      end
      if (out_valid && out_ready) begin
        got.value = out_value;
        got.x = out_x;
        got.y = out_y;
        got.outside = outside;
        if (rotated_q.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output transfer: value %0d at (%0d,%0d) outside %0b",
                     got.value, got.x, got.y, got.outside);
        end else begin
          want = rotated_q.pop_front();
          if (got != want) begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %0d (%0d,%0d) outside %0b, got %0d (%0d,%0d) %0b",
                       want.value, want.x, want.y, want.outside,
                       got.value, got.x, got.y, got.outside);
          end
        end
      end
    end
    pending = rotated_q.size();
  end
endmodule

[dv/testbench.sv]
// Top of the rotation unit testbench: clock, reset, stimulus and verdict.
// Depends on bir_pkg, bilinear_image_rotation_unit and bir_checker.
module testbench;
  import bir_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int FILL_SIDE  = 16;

  logic clk, rst;
  logic in_valid, in_ready, kind;
  logic [SIDE_W-1:0] pix_x, pix_y, out_x, out_y;
  logic [PIX_W-1:0] pix_value, out_value;
  logic out_valid, out_ready, outside;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [ANGLE_W-1:0] cfg_data;
  int fail_count, pending, idle_cycles, loads_sent, requests_sent, settings_used;
  bit long_hold_wanted;
  // Which pixels have been loaded, and the rotation currently programmed.
  bit loaded [MAX_SIDE*MAX_SIDE];
  int cur_w;
  longint cur_s, cur_c;

  bilinear_image_rotation_unit dut (.*);

  bir_checker chk (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Receiver: mostly ready, short and long stalls, and one long hold-off on request.
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (long_hold_wanted) begin
        long_hold_wanted = 1'b0;
        hold = 300;
        out_ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0:       hold = $urandom_range(10, 40);
          1, 2, 3: hold = $urandom_range(1, 3);
          default: hold = 0;
        endcase
        out_ready <= (hold == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // True when a request either falls outside or only reads pixels that have been loaded.
  function automatic bit reads_loaded(int dx, int dy);
    longint w, x15, y15, fx, fy, hx, hy;
    w = (cur_w > MAX_SIDE) ? MAX_SIDE : cur_w;
    x15 = w*16384 - w*(cur_c + cur_s) + 2*dx*cur_c + 2*dy*cur_s;
    y15 = w*16384 - w*(cur_c - cur_s) - 2*dx*cur_s + 2*dy*cur_c;
    fx = x15 >>> 15;
    fy = y15 >>> 15;
    hx = fx + (((x15 & 64'h7FFF) != 0) ? 1 : 0);
    hy = fy + (((y15 & 64'h7FFF) != 0) ? 1 : 0);
    if (fx < 0 || fy < 0 || hx >= w || hy >= w) return 1'b1;
    return loaded[fy*MAX_SIDE + fx] && loaded[fy*MAX_SIDE + hx] &&
           loaded[hy*MAX_SIDE + fx] && loaded[hy*MAX_SIDE + hx];
  endfunction

  // Each task starts and ends in the time step of a rising edge.
  task automatic send_item(logic k, logic [7:0] x, logic [7:0] y, logic [7:0] v, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    pix_x     <= x;
    pix_y     <= y;
    pix_value <= v;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    if (k == KIND_LOAD) begin
      loads_sent++;
      loaded[int'(y)*MAX_SIDE + int'(x)] = 1'b1;
    end else begin
      requests_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    // Loads give no result and may still be in the pipeline.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rotation(logic [8:0] w, logic [15:0] s, logic [15:0] c);
    drain();
    write_reg(REG_WIDTH, {7'd0, w});
    write_reg(REG_SIN, s);
    write_reg(REG_COS, c);
    cur_w = int'(w);
    cur_s = longint'($signed(s));
    cur_c = longint'($signed(c));
    settings_used++;
  endtask

  task automatic random_phase(int n);
    int lim, rx, ry, tries;
    bit found;
    lim = (cur_w < 2) ? 2 : ((cur_w > 256) ? 256 : cur_w);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(KIND_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), pick_gap());
      end else begin
        found = 1'b0;
        rx = 0;
        ry = 0;
        for (tries = 0; tries < 20 && !found; tries++) begin
          if ($urandom_range(0, 3) == 0) begin
            rx = $urandom_range(0, 255);
            ry = $urandom_range(0, 255);
          end else begin
            rx = $urandom_range(0, lim-1);
            ry = $urandom_range(0, lim-1);
          end
          found = reads_loaded(rx, ry);
        end
        if (found)
          send_item(1'b1, 8'(rx), 8'(ry), 8'($urandom_range(0, 255)), pick_gap());
        else
          send_item(KIND_LOAD, 8'($urandom_range(0, FILL_SIDE-1)),
                    8'($urandom_range(0, FILL_SIDE-1)), 8'($urandom_range(0, 255)),
                    pick_gap());
      end
    end
  endtask

  initial begin
    int s, c;
    rst = 1'b1;
    in_valid = 1'b0; kind = 1'b0; pix_x = '0; pix_y = '0; pix_value = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    long_hold_wanted = 1'b0;
    loads_sent = 0; requests_sent = 0; settings_used = 0;
    cur_w = 256; cur_s = 0; cur_c = 16384;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the top-left corner first; later requests are only sent when every
    // pixel they read has been loaded.
    for (int y = 0; y < FILL_SIDE; y++)
      for (int x = 0; x < FILL_SIDE; x++)
        send_item(KIND_LOAD, 8'(x), 8'(y), 8'($urandom_range(0, 255)),
                  ($urandom_range(0, 63) == 0) ? $urandom_range(1, 3) : 0);

    // Directed part: corners, extreme values, beyond the image, under reset and other rotations.
    send_item(KIND_LOAD, 8'd0, 8'd0, 8'd255, 0);
    send_item(KIND_LOAD, 8'd255, 8'd255, 8'd0, 0);
    send_item(KIND_LOAD, 8'd0, 8'd255, 8'd77, 0);
    send_item(KIND_LOAD, 8'd255, 8'd0, 8'd200, 0);
    send_item(1'b1, 8'd0, 8'd0, 8'hFF, 0);
    send_item(1'b1, 8'd255, 8'd255, 8'h00, 0);
    send_item(1'b1, 8'd0, 8'd255, 8'h00, 1);
    send_item(1'b1, 8'd255, 8'd0, 8'h00, 0);
    set_rotation(9'd16, 16'sd11585, 16'sd11585);
    send_item(1'b1, 8'd7, 8'd7, 8'd0, 0);
    send_item(1'b1, 8'd0, 8'd0, 8'd0, 0);
    send_item(1'b1, 8'd15, 8'd0, 8'd0, 0);
    send_item(1'b1, 8'd200, 8'd3, 8'd0, 0);
    set_rotation(9'd0, 16'sd0, 16'sd16384);
    send_item(1'b1, 8'd0, 8'd0, 8'd0, 0);
    set_rotation(9'd1, 16'sd0, 16'sd16384);
    send_item(1'b1, 8'd0, 8'd0, 8'd0, 0);
    send_item(1'b1, 8'd1, 8'd0, 8'd0, 0);
    set_rotation(9'd511, -16'sd16384, 16'sd0);
    send_item(1'b1, 8'd0, 8'd0, 8'd0, 0);
    send_item(1'b1, 8'd5, 8'd250, 8'd0, 0);
    set_rotation(9'd2, 16'sd32767, -16'sd32768);
    send_item(1'b1, 8'd1, 8'd1, 8'd0, 0);
    send_item(1'b1, 8'd0, 8'd1, 8'd0, 0);

    // Random part; the first phase holds the receiver off while the input keeps coming.
    set_rotation(9'd256, 16'sd5000, 16'sd15600);
    long_hold_wanted = 1'b1;
    random_phase(200);
    set_rotation(9'd2, 16'sd16384, 16'sd0);
    random_phase(120);
    set_rotation(9'd300, -16'sd16384, -16'sd16384);
    random_phase(120);
    set_rotation(9'd64, 16'sd16384, 16'sd16384);
    random_phase(120);
    for (int p = 0; p < 7; p++) begin
      s = $urandom_range(0, 32768) - 16384;
      c = $urandom_range(0, 32768) - 16384;
      case (p % 3)
        0: set_rotation(9'($urandom_range(2, 24)), 16'(s), 16'(c));
        1: set_rotation(9'($urandom_range(2, 256)), 16'(s), 16'(c));
        default: set_rotation(9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
      endcase
      random_phase(130);
    end

    drain();
    $display("covered %0d loads and %0d rotated pixel requests over %0d rotation settings",
             loads_sent, requests_sent, settings_used);
    $display("including corners, widths 0 to 511 and out-of-range sine and cosine");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
